### hdl/asconp_pkg.sv
// Shared types, constants and helpers for the Ascon permutation block.
`timescale 1ns / 1ps
package asconp_pkg;

	localparam int WORD_W   = 64;
	localparam int WORDS    = 5;
	localparam int REPEAT_W = 20;
	localparam int ROUND_W  = 4;

	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(11);

	typedef logic [WORD_W-1:0] asconp_word_t;
	typedef logic [WORDS-1:0][WORD_W-1:0] asconp_state_t;
	typedef logic [REPEAT_W-1:0] asconp_count_t;

	// Register indexes on the configuration channel.
	typedef enum logic {
		REG_OUTER = 1'b0,
		REG_INNER = 1'b1
	} asconp_reg_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic                advance;   // apply one round to the state
		logic                finish;    // move the state into the output register
		logic [ROUND_W-1:0]  round_idx; // round index in the 12-round schedule
	} asconp_ctl_t;

	function automatic asconp_word_t rotr(input asconp_word_t v, input int unsigned n);
		rotr = (v >> n) | (v << (WORD_W - n));
	endfunction

	// Round constant byte: upper nibble counts down, lower nibble counts up.
	function automatic logic [7:0] round_const(input logic [ROUND_W-1:0] r);
		logic [3:0] hi;
		hi = 4'hF - r;
		round_const = {hi, r};
	endfunction

endpackage

### hdl/ascon_p12_permutation.sv
// Top level of the repeated Ascon permutation block.
`timescale 1ns / 1ps
// Applies the Ascon permutation (ROUND_COUNT rounds, 12 by default) to a
// 320-bit state outer_repeats * inner_repeats times. One round runs per
// clock through a single shared round unit; when either count is zero the
// input is returned unchanged. The sequencer goes idle on the edge that
// fills the output register, and a full output register stalls that
// finish, so the next word is taken only after the result has been
// registered. The state register and the round unit form the datapath
// loop; the sequencer steps round, inner and outer counters.
// s_axis_tready is high only while that loop is idle; a finished word
// waits in the output register, so a new word may be accepted while the
// previous result is still unread. Write the two count registers on the
// cfg channel only while idle; cfg_ready is always high.
module ascon_p12_permutation #(
	parameter int ROUND_COUNT = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,   // 0: outer_repeats, 1: inner_repeats
	input  logic [19:0]  cfg_data,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [319:0] s_axis_tdata, // word_zero, word_one, word_two, word_three, word_four
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [319:0] m_axis_tdata  // out_zero, out_one, out_two, out_three, out_four
);
	import asconp_pkg::*;

	asconp_count_t  outer_q;
	asconp_count_t  inner_q;
	asconp_state_t  state_q;
	asconp_state_t  round_out;
	asconp_state_t  out_q;
	logic           out_valid_q;
	logic           out_free;
	logic           in_accept;
	asconp_ctl_t    ctl;

	assign cfg_ready     = 1'b1;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	// output slot is free when empty or being drained this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Hold the repetition counts; write them only while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= REPEAT_W'(1);
			inner_q <= REPEAT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (asconp_reg_t'(cfg_index))
				REG_OUTER: outer_q <= cfg_data;
				REG_INNER: inner_q <= cfg_data;
				default:   outer_q <= outer_q;
			endcase
		end
	end

	asconp_seq #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_accept),
		.out_free      (out_free),
		.outer_repeats (outer_q),
		.inner_repeats (inner_q),
		.ready         (s_axis_tready),
		.ctl           (ctl)
	);

	asconp_round u_round (
		.state_in  (state_q),
		.round_idx (ctl.round_idx),
		.state_out (round_out)
	);

	// Working state: load on accept, advance one round per cycle while running.
	always_ff @(posedge clk) begin
		if (in_accept)
			state_q <= s_axis_tdata;
		else if (ctl.advance)
			state_q <= round_out;
	end

	// Output register: fill on finish, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish)
			out_q <= state_q;
	end

	// Busy right after taking a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("input accepted twice without finishing");

	// Never accept while rounds are still running.
	a_no_accept_running: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |-> !s_axis_tready)
		else $error("ready high while rounds in flight");

	// A finished word never overwrites an unread result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> (!out_valid_q || m_axis_tready))
		else $error("pending result overwritten");

	// Round index stays within the schedule while running.
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |-> (ctl.round_idx <= LAST_ROUND))
		else $error("round index out of schedule");

endmodule

### hdl/asconp_round.sv
// One Ascon round: constant addition, bitsliced s-box and linear layer.
`timescale 1ns / 1ps
module asconp_round (
	input  asconp_pkg::asconp_state_t            state_in,
	input  logic [asconp_pkg::ROUND_W-1:0]       round_idx,
	output asconp_pkg::asconp_state_t            state_out
);
	import asconp_pkg::*;

	asconp_word_t a0, a1, a2, a3, a4;
	asconp_word_t b0, b1, b2, b3, b4;
	asconp_word_t c0, c1, c2, c3, c4;
	asconp_word_t s2;

	always_comb begin
		s2 = state_in[2] ^ {{(WORD_W-8){1'b0}}, round_const(round_idx)};

		a0 = state_in[0] ^ state_in[4];
		a4 = state_in[4] ^ state_in[3];
		a2 = s2 ^ state_in[1];
		a1 = state_in[1];
		a3 = state_in[3];

		// chi-like layer
		b0 = a0 ^ (~a1 & a2);
		b1 = a1 ^ (~a2 & a3);
		b2 = a2 ^ (~a3 & a4);
		b3 = a3 ^ (~a4 & a0);
		b4 = a4 ^ (~a0 & a1);

		c1 = b1 ^ b0;
		c0 = b0 ^ b4;
		c3 = b3 ^ b2;
		c2 = ~b2;
		c4 = b4;

		state_out[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
		state_out[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
		state_out[2] = c2 ^ rotr(c2, 1)  ^ rotr(c2, 6);
		state_out[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
		state_out[4] = c4 ^ rotr(c4, 7)  ^ rotr(c4, 41);
	end

endmodule

### hdl/asconp_seq.sv
// Round, inner and outer repetition sequencer for the Ascon permutation.
`timescale 1ns / 1ps
module asconp_seq #(
	parameter int ROUND_COUNT = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        out_free,
	input  asconp_pkg::asconp_count_t   outer_repeats,
	input  asconp_pkg::asconp_count_t   inner_repeats,
	output logic                        ready,
	output asconp_pkg::asconp_ctl_t     ctl
);
	import asconp_pkg::*;

	localparam logic [ROUND_W-1:0] FIRST_ROUND = ROUND_W'(12 - ROUND_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t             state_q;
	logic [ROUND_W-1:0] round_q;
	asconp_count_t      inner_q;
	asconp_count_t      outer_q;

	assign ready         = (state_q == ST_IDLE);
	assign ctl.advance   = (state_q == ST_RUN);
	assign ctl.finish    = (state_q == ST_HOLD) && out_free;
	assign ctl.round_idx = round_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= FIRST_ROUND;
			inner_q <= '0;
			outer_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						round_q <= FIRST_ROUND;
						inner_q <= REPEAT_W'(1);
						outer_q <= REPEAT_W'(1);
						// zero repetitions pass the word straight through
						if (outer_repeats == '0 || inner_repeats == '0)
							state_q <= ST_HOLD;
						else
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (round_q == LAST_ROUND) begin
						round_q <= FIRST_ROUND;
						if (inner_q == inner_repeats) begin
							inner_q <= REPEAT_W'(1);
							if (outer_q == outer_repeats)
								state_q <= ST_HOLD;
							else
								outer_q <= outer_q + REPEAT_W'(1);
						end else begin
							inner_q <= inner_q + REPEAT_W'(1);
						end
					end else begin
						round_q <= round_q + ROUND_W'(1);
					end
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sim/ascon_p12_permutation_tb.sv
// Self-checking testbench for the repeated Ascon permutation block.
`timescale 1ns / 1ps
module ascon_p12_permutation_tb;
	import asconp_pkg::*;

	localparam int ROUND_COUNT = 12;
	localparam int FIRST_ROUND = 12 - ROUND_COUNT;
	localparam asconp_count_t COUNT_MAX = '1;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_index = REG_OUTER;
	logic [19:0]   cfg_data = '0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [319:0]  s_axis_tdata = '0;  // word_zero .. word_four, 64 bits each
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [319:0]  m_axis_tdata;       // out_zero .. out_four, 64 bits each

	ascon_p12_permutation #(
		.ROUND_COUNT(ROUND_COUNT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Shadow copy of the two count registers, updated on each cfg handshake.
	asconp_count_t outer_count = 1;
	asconp_count_t inner_count = 1;

	asconp_state_t pending_words[$];   // words waiting to be driven
	asconp_state_t permuted_states[$]; // expected results, oldest first
	int unsigned   failures = 0;

	// Handshake flags seen at the last rising edge, read by the drivers at the falling edge.
	logic          in_accepted = 1'b0;
	logic          out_accepted = 1'b0;
	logic [3:0]    in_wait = '0;
	logic [3:0]    out_wait = 4'd3;
	logic [3:0]    out_draw = '0;
	int unsigned   in_calm = 0;
	int unsigned   out_calm = 0;
	asconp_state_t want_state;
	asconp_state_t got_state;

	initial begin
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic asconp_word_t rot_right(asconp_word_t v, int unsigned n);
		logic [127:0] both;
		both = {v, v} >> n;
		return both[63:0];
	endfunction

	// One round: constant into word 2, bitsliced s-box, then the linear diffusion layer.
	function automatic asconp_state_t ascon_round(asconp_state_t s, int unsigned r);
		asconp_word_t x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
		s[2] ^= {56'd0, 4'(15 - r), 4'(r)};
		x0 = s[0] ^ s[4];
		x4 = s[4] ^ s[3];
		x2 = s[2] ^ s[1];
		x1 = s[1];
		x3 = s[3];
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 ^= t1;
		x1 ^= t2;
		x2 ^= t3;
		x3 ^= t4;
		x4 ^= t0;
		x1 ^= x0;
		x0 ^= x4;
		x3 ^= x2;
		x2 = ~x2;
		s[0] = x0 ^ rot_right(x0, 19) ^ rot_right(x0, 28);
		s[1] = x1 ^ rot_right(x1, 61) ^ rot_right(x1, 39);
		s[2] = x2 ^ rot_right(x2, 1) ^ rot_right(x2, 6);
		s[3] = x3 ^ rot_right(x3, 10) ^ rot_right(x3, 17);
		s[4] = x4 ^ rot_right(x4, 7) ^ rot_right(x4, 41);
		return s;
	endfunction

	// Full permutation outer * inner times; a zero count leaves the state untouched.
	function automatic asconp_state_t permute_repeated(asconp_state_t s, asconp_count_t outer,
			asconp_count_t inner);
		if (outer == 0 || inner == 0)
			return s;
		for (int unsigned m = 0; m < outer; m++)
			for (int unsigned n = 0; n < inner; n++)
				for (int unsigned i = 0; i < ROUND_COUNT; i++)
					s = ascon_round(s, FIRST_ROUND + i);
		return s;
	endfunction

	// ---------------------------------------------------------------- input driver

	// Present the next word once the previous one is taken, after a random gap;
	// now and then run a stretch of words back to back.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			in_wait <= '0;
		end else if (!s_axis_tvalid || in_accepted) begin
			if (in_wait != 0) begin
				s_axis_tvalid <= 1'b0;
				in_wait <= in_wait - 4'd1;
			end else if (pending_words.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_words.pop_front();
				in_wait <= (in_calm != 0) ? 4'd0 : 4'($urandom_range(0, 15));
				if (in_calm != 0)
					in_calm <= in_calm - 1;
				else if ($urandom_range(0, 15) == 0)
					in_calm <= $urandom_range(10, 60);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- output stall

	// After each result word, hold tready low for a random gap, which may be empty.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (out_accepted) begin
			if (out_calm != 0) begin
				out_wait <= '0;
				m_axis_tready <= 1'b1;
				out_calm <= out_calm - 1;
			end else begin
				out_draw = 4'($urandom_range(0, 15));
				out_wait <= out_draw;
				m_axis_tready <= (out_draw == 4'd0);
				if ($urandom_range(0, 15) == 0)
					out_calm <= $urandom_range(10, 60);
			end
		end else if (out_wait != 0) begin
			out_wait <= out_wait - 4'd1;
			m_axis_tready <= (out_wait == 4'd1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		in_accepted <= arst_n && s_axis_tvalid && s_axis_tready;
		out_accepted <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == REG_OUTER)
				outer_count = cfg_data;
			else
				inner_count = cfg_data;
		end
		// Predict the result of every accepted word with the counts now in force.
		if (arst_n && s_axis_tvalid && s_axis_tready)
			permuted_states.insert(permuted_states.size(),
				permute_repeated(s_axis_tdata, outer_count, inner_count));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_state = m_axis_tdata;
			if (permuted_states.size() == 0) begin
				failures++;
				$display("%0t: result word with nothing expected: expected none, got %h",
					$time, m_axis_tdata);
			end else begin
				want_state = permuted_states.pop_front();
				for (int k = 0; k < WORDS; k++) begin
					if (got_state[k] !== want_state[k]) begin
						failures++;
						$display("%0t: state word %0d mismatch: expected %h, got %h",
							$time, k, want_state[k], got_state[k]);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic asconp_word_t random_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return asconp_word_t'(1) << $urandom_range(0, 63);
			3: return ~(asconp_word_t'(1) << $urandom_range(0, 63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_random(int unsigned count);
		asconp_state_t s;
		repeat (count) begin
			for (int k = 0; k < WORDS; k++)
				s[k] = random_word();
			pending_words.insert(pending_words.size(), s);
		end
	endtask

	task automatic push_fill(asconp_word_t w);
		asconp_state_t s;
		for (int k = 0; k < WORDS; k++)
			s[k] = w;
		pending_words.insert(pending_words.size(), s);
	endtask

	// Block until every queued word has been taken and every result has come back.
	task automatic wait_drained();
		while (pending_words.size() != 0 || s_axis_tvalid || permuted_states.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(asconp_reg_t idx, asconp_count_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram both counts while idle, then run a batch of random words.
	task automatic run_phase(asconp_count_t outer, asconp_count_t inner, int unsigned count);
		wait_drained();
		write_reg(REG_OUTER, outer);
		write_reg(REG_INNER, inner);
		push_random(count);
	endtask

	initial begin
		asconp_state_t s;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset counts (one permutation each).
		push_fill('0);
		push_fill('1);
		push_fill({16{4'hA}});
		push_fill({16{4'h5}});
		for (int k = 0; k < WORDS; k++) begin
			s = '0;
			s[k] = 64'd1;
			pending_words.insert(pending_words.size(), s);
			s[k] = 64'h8000_0000_0000_0000;
			pending_words.insert(pending_words.size(), s);
			s[k] = '1;
			pending_words.insert(pending_words.size(), s);
		end

		// Zero repetitions pass the state through unchanged.
		wait_drained();
		write_reg(REG_OUTER, 0);
		push_fill('0);
		push_fill('1);
		wait_drained();
		write_reg(REG_OUTER, 1);
		write_reg(REG_INNER, 0);
		push_fill({16{4'hC}});
		push_fill({16{4'h3}});

		// Random words across a range of count settings, extremes included.
		run_phase(1, 1, 600);
		run_phase(2, 1, 150);
		run_phase(1, 3, 150);
		run_phase(0, asconp_count_t'($urandom_range(1, 20'hFFFFF)), 100);
		run_phase(asconp_count_t'($urandom_range(1, 20'hFFFFF)), 0, 100);
		run_phase(3, 4, 60);
		run_phase(COUNT_MAX, 0, 60);
		run_phase(0, COUNT_MAX, 60);
		run_phase(0, 0, 40);
		run_phase(5, 1, 100);
		run_phase(1, 2, 120);

		// Drain, then give any stray result time to show up.
		wait_drained();
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("PASS ascon_p12_permutation");
		else
			$display("FAIL ascon_p12_permutation");
		$finish;
	end

	// Watchdog: ends the run with a failure if it has not finished in time.
	initial begin
		#10_000_000;
		$display("FAIL ascon_p12_permutation");
		$finish;
	end

endmodule
